[hw/rtl/dpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, widths and helpers for the depth pixel deprojection pipeline.
// ----------------------------------------------------------------------------
package dpd_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam int A_W = 30;      // depth * 8192 + 62
	localparam int MUL_W = 31;    // reciprocal of 125, Q.37
	localparam int ZC_W = 23;     // camera z, unsigned Q.16 metres
	localparam int D_W = 18;      // pixel offset, signed Q.4
	localparam int T_W = 31;      // scaled offset, signed Q.16
	localparam int XC_W = 37;     // camera x / y, signed Q.16
	localparam int ACC_W = 56;    // world accumulator
	localparam int NACC_W = 34;   // normal accumulator

	localparam logic [MUL_W-1:0] DIV125_MUL = 31'd1099511627;
	localparam int DIV125_SHIFT = 37;
	localparam logic [A_W-1:0] DIV125 = 30'd125;
	localparam logic [A_W-1:0] DEPTH_BIAS = 30'd62;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_FOCAL_X = 3'd0,
		REG_INV_FOCAL_Y = 3'd1,
		REG_CENTER_X    = 3'd2,
		REG_CENTER_Y    = 3'd3,
		REG_POSE_ROW_X  = 3'd4,
		REG_POSE_ROW_Y  = 3'd5,
		REG_POSE_ROW_Z  = 3'd6
	} cfg_reg_t;

	localparam logic [63:0] POSE_ROW_X_RST = 64'h4000_0000_0000_0000;
	localparam logic [63:0] POSE_ROW_Y_RST = 64'h0000_4000_0000_0000;
	localparam logic [63:0] POSE_ROW_Z_RST = 64'h0000_0000_4000_0000;

	typedef struct packed {
		logic [11:0]        pixel_col;
		logic [11:0]        pixel_row;
		logic [15:0]        depth_mm;
		logic signed [15:0] normal_in_x;
		logic signed [15:0] normal_in_y;
		logic signed [15:0] normal_in_z;
		logic [7:0]         color_red;
		logic [7:0]         color_green;
		logic [7:0]         color_blue;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic signed [15:0] normal_out_x;
		logic signed [15:0] normal_out_y;
		logic signed [15:0] normal_out_z;
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
	} point_t;

	function automatic logic signed [31:0] sat_world(input logic signed [41:0] v);
		logic fits;
		fits = (&v[41:31]) || !(|v[41:31]);
		if (fits)
			return v[31:0];
		else if (v[41])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	function automatic logic signed [15:0] sat_normal(input logic signed [19:0] v);
		logic fits;
		fits = (&v[19:15]) || !(|v[19:15]);
		if (fits)
			return v[15:0];
		else if (v[19])
			return 16'sh8000;
		else
			return 16'sh7fff;
	endfunction

endpackage

[hw/rtl/dpd_depth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_depth
// Depth in millimetres to camera z in Q.16 metres, rounded, by a reciprocal
// multiply and one correction step. Result registered in stage 3.
// ----------------------------------------------------------------------------
module dpd_depth import dpd_pkg::*; (
	input  logic            clk,
	input  logic [15:0]     depth_mm,
	output logic [ZC_W-1:0] zc_s3
);

	logic [A_W-1:0]         a_s1;
	logic [A_W-1:0]         a_s2;
	logic [A_W+MUL_W-1:0]   p_s2;
	logic [ZC_W-1:0]        q0;
	logic [A_W-1:0]         rem;

	// round(d*65536/1000) == floor((d*8192 + 62) / 125)
	always_ff @(posedge clk) begin
		a_s1 <= {1'b0, depth_mm, 13'b0} + DEPTH_BIAS;
		a_s2 <= a_s1;
		p_s2 <= a_s1 * DIV125_MUL;
		zc_s3 <= (rem >= DIV125) ? q0 + 1'b1 : q0;
	end

	always_comb begin
		q0 = p_s2[DIV125_SHIFT+ZC_W-1:DIV125_SHIFT];
		rem = a_s2 - A_W'({7'b0, q0} * DIV125);
	end

endmodule

[hw/rtl/dpd_lateral.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_lateral
// Camera x (or y) from pixel index, principal point and reciprocal focal
// length: offset, scale, multiply by depth. Result registered in stage 5.
// ----------------------------------------------------------------------------
module dpd_lateral import dpd_pkg::*; (
	input  logic                   clk,
	input  logic [11:0]            pix,
	input  logic [15:0]            center,
	input  logic [31:0]            inv_focal,
	input  logic [ZC_W-1:0]        zc_s3,
	output logic signed [XC_W-1:0] xc_s5
);

	localparam int PROD_W = D_W + 33;
	localparam int M_W = ZC_W + 1 + T_W;
	localparam logic signed [PROD_W-1:0] RND20 = PROD_W'(1 << 19);
	localparam logic signed [M_W-1:0] RND16 = M_W'(1 << 16 - 1);

	logic signed [D_W-1:0]    d_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [T_W-1:0]    t_s3;
	logic signed [M_W-1:0]    m_s4;

	always_ff @(posedge clk) begin
		d_s1 <= $signed({2'b00, pix, 4'b0000}) - $signed({2'b00, center});
		prod_s2 <= d_s1 * $signed({1'b0, inv_focal});
		t_s3 <= T_W'((prod_s2 + RND20) >>> 20);
		m_s4 <= $signed({1'b0, zc_s3}) * t_s3;
		xc_s5 <= XC_W'((m_s4 + RND16) >>> 16);
	end

endmodule

[hw/rtl/dpd_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_rotate
// One row of the rigid transform: world coordinate (rotation plus
// translation) and rotated normal, both rounded and saturated, stage 7.
// ----------------------------------------------------------------------------
module dpd_rotate import dpd_pkg::*; (
	input  logic                   clk,
	input  logic [63:0]            pose_row,
	input  logic signed [15:0]     nx_s1,
	input  logic signed [15:0]     ny_s1,
	input  logic signed [15:0]     nz_s1,
	input  logic signed [XC_W-1:0] xc_s5,
	input  logic signed [XC_W-1:0] yc_s5,
	input  logic [ZC_W-1:0]        zc_s5,
	output logic signed [31:0]     world_s7,
	output logic signed [15:0]     nrm_s7
);

	localparam int WP_W = XC_W + 16;
	localparam int WZ_W = ZC_W + 17;
	localparam logic signed [NACC_W-1:0] NRND = NACC_W'(1 << 13);
	localparam logic signed [ACC_W-1:0] WRND = ACC_W'(1 << 13);

	logic signed [15:0] r0, r1, r2;
	logic signed [31:0] np0_s2, np1_s2, np2_s2;
	logic signed [15:0] nrm_s3, nrm_s4, nrm_s5, nrm_s6;
	logic signed [WP_W-1:0] wp0_s6, wp1_s6;
	logic signed [WZ_W-1:0] wp2_s6;
	logic signed [NACC_W-1:0] nacc;
	logic signed [ACC_W-1:0] wacc;
	logic signed [ACC_W-1:0] trans;

	always_comb begin
		r0 = pose_row[63:48];
		r1 = pose_row[47:32];
		r2 = pose_row[31:16];
		trans = $signed({{(ACC_W-36){pose_row[15]}}, pose_row[15:0], 20'b0});
		nacc = NACC_W'(np0_s2) + NACC_W'(np1_s2) + NACC_W'(np2_s2) + NRND;
		wacc = ACC_W'(wp0_s6) + ACC_W'(wp1_s6) + ACC_W'(wp2_s6) + trans + WRND;
	end

	always_ff @(posedge clk) begin
		np0_s2 <= r0 * nx_s1;
		np1_s2 <= r1 * ny_s1;
		np2_s2 <= r2 * nz_s1;
		nrm_s3 <= sat_normal(20'(nacc >>> 14));
		nrm_s4 <= nrm_s3;
		nrm_s5 <= nrm_s4;
		nrm_s6 <= nrm_s5;
		nrm_s7 <= nrm_s6;
		wp0_s6 <= r0 * xc_s5;
		wp1_s6 <= r1 * yc_s5;
		wp2_s6 <= r2 * $signed({1'b0, zc_s5});
		world_s7 <= sat_world(42'(wacc >>> 14));
	end

endmodule

[hw/rtl/depth_pixel_deproject.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_deproject
// Pinhole deprojection of one depth pixel and rigid camera-to-world transform.
// One pixel per clock from the start beat to the done strobe, through seven
// register stages: depth/offset, multiply, round, z*t, round, rotate multiply,
// accumulate and saturate. busy never rises; results cannot stall.
// Reset clears valids, zeroes the intrinsics and loads the identity pose.
// ----------------------------------------------------------------------------
module depth_pixel_deproject import dpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pixel_t                pixel,
	output logic                  done,
	output point_t                result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [31:0] inv_focal_x_q, inv_focal_y_q;
	logic [15:0] center_x_q, center_y_q;
	logic [63:0] pose_row_x_q, pose_row_y_q, pose_row_z_q;

	logic [6:0] vld_q;

	logic signed [15:0] nx_s1, ny_s1, nz_s1;
	logic [23:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5, rgb_s6, rgb_s7;
	logic [ZC_W-1:0] zc_s3, zc_s4, zc_s5;
	logic signed [XC_W-1:0] xc_s5, yc_s5;
	logic signed [31:0] wx_s7, wy_s7, wz_s7;
	logic signed [15:0] nox_s7, noy_s7, noz_s7;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q <= '0;
			inv_focal_y_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			pose_row_x_q <= POSE_ROW_X_RST;
			pose_row_y_q <= POSE_ROW_Y_RST;
			pose_row_z_q <= POSE_ROW_Z_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data[31:0];
				REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data[31:0];
				REG_CENTER_X:    center_x_q <= cfg_data[15:0];
				REG_CENTER_Y:    center_y_q <= cfg_data[15:0];
				REG_POSE_ROW_X:  pose_row_x_q <= cfg_data;
				REG_POSE_ROW_Y:  pose_row_y_q <= cfg_data;
				REG_POSE_ROW_Z:  pose_row_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		nx_s1 <= pixel.normal_in_x;
		ny_s1 <= pixel.normal_in_y;
		nz_s1 <= pixel.normal_in_z;
		rgb_s1 <= {pixel.color_red, pixel.color_green, pixel.color_blue};
		rgb_s2 <= rgb_s1;
		rgb_s3 <= rgb_s2;
		rgb_s4 <= rgb_s3;
		rgb_s5 <= rgb_s4;
		rgb_s6 <= rgb_s5;
		rgb_s7 <= rgb_s6;
		zc_s4 <= zc_s3;
		zc_s5 <= zc_s4;
	end

	dpd_depth u_depth (
		.clk      (clk),
		.depth_mm (pixel.depth_mm),
		.zc_s3    (zc_s3)
	);

	dpd_lateral u_lat_x (
		.clk       (clk),
		.pix       (pixel.pixel_col),
		.center    (center_x_q),
		.inv_focal (inv_focal_x_q),
		.zc_s3     (zc_s3),
		.xc_s5     (xc_s5)
	);

	dpd_lateral u_lat_y (
		.clk       (clk),
		.pix       (pixel.pixel_row),
		.center    (center_y_q),
		.inv_focal (inv_focal_y_q),
		.zc_s3     (zc_s3),
		.xc_s5     (yc_s5)
	);

	dpd_rotate u_rot_x (
		.clk      (clk),
		.pose_row (pose_row_x_q),
		.nx_s1    (nx_s1),
		.ny_s1    (ny_s1),
		.nz_s1    (nz_s1),
		.xc_s5    (xc_s5),
		.yc_s5    (yc_s5),
		.zc_s5    (zc_s5),
		.world_s7 (wx_s7),
		.nrm_s7   (nox_s7)
	);

	dpd_rotate u_rot_y (
		.clk      (clk),
		.pose_row (pose_row_y_q),
		.nx_s1    (nx_s1),
		.ny_s1    (ny_s1),
		.nz_s1    (nz_s1),
		.xc_s5    (xc_s5),
		.yc_s5    (yc_s5),
		.zc_s5    (zc_s5),
		.world_s7 (wy_s7),
		.nrm_s7   (noy_s7)
	);

	dpd_rotate u_rot_z (
		.clk      (clk),
		.pose_row (pose_row_z_q),
		.nx_s1    (nx_s1),
		.ny_s1    (ny_s1),
		.nz_s1    (nz_s1),
		.xc_s5    (xc_s5),
		.yc_s5    (yc_s5),
		.zc_s5    (zc_s5),
		.world_s7 (wz_s7),
		.nrm_s7   (noz_s7)
	);

	assign done = vld_q[6];

	always_comb begin
		result.world_x = wx_s7;
		result.world_y = wy_s7;
		result.world_z = wz_s7;
		result.normal_out_x = nox_s7;
		result.normal_out_y = noy_s7;
		result.normal_out_z = noz_s7;
		result.red_out = rgb_s7[23:16];
		result.green_out = rgb_s7[15:8];
		result.blue_out = rgb_s7[7:0];
	end

endmodule
